// ----- sv/pls_pkg.sv -----
// Shared types and codes for the positional list store.
`default_nettype none

package pls_pkg;

    // Operation codes carried by the cmd field
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PEEK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Result error codes
    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_FULL  = 2'd2,
        ERR_EMPTY = 2'd3
    } err_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture the input word and check it
        logic shift_init;  // set the source pointer for a shift pass
        logic shift_read;  // read one entry of the shift pass
        logic peek_read;   // read the entry at the position
        logic write_item;  // write the new item at the position
        logic finish;      // update occupancy and present the result
    } pls_ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        op_t  op;          // captured operation
        logic ok;          // captured operation passed its checks
        logic at_end;      // nothing to move (insert at tail, remove of last)
        logic src_last;    // source pointer is on the last entry to move
    } pls_sts_t;

endpackage

`default_nettype wire

// ----- sv/pls_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/pls_dp.sv -----
// Datapath: entry RAM, occupancy, shift pointers and result registers.
`default_nettype none

module pls_dp
    import pls_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pls_ctl_t                      ctl,
    output pls_sts_t                           sts,
    input  wire logic [1:0]                    cmd_in,
    input  wire logic [$clog2(CAPACITY+1)-1:0] position,
    input  wire logic [ITEM_WIDTH-1:0]         item_in,
    output logic                               done,
    output logic      [ITEM_WIDTH-1:0]         item_out,
    output logic      [1:0]                    error_code,
    output logic      [$clog2(CAPACITY+1)-1:0] count,
    output logic                               is_full,
    output logic                               is_empty
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0]  CAP_C   = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0]  CNT_ONE = CNT_W'(1);
    localparam logic [ADDR_W-1:0] ADR_ONE = ADDR_W'(1);

    // Captured word and checks
    op_t                   op_reg;
    logic [CNT_W-1:0]      pos_reg;
    logic [ITEM_WIDTH-1:0] item_reg;
    err_t                  err_reg;
    err_t                  err_in;
    op_t                   op_in;

    // Occupancy and shift pass
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [ADDR_W-1:0] dest_reg, dest_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  pos_p1;

    // Result registers
    logic                  done_reg;
    logic [ITEM_WIDTH-1:0] item_out_reg, item_out_next;
    err_t                  err_out_reg, err_out_next;

    // RAM ports
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ITEM_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ITEM_WIDTH-1:0] ram_rdata;

    assign op_in  = op_t'(cmd_in);
    assign cnt_m1 = count_reg - CNT_ONE;
    assign pos_p1 = pos_reg + CNT_ONE;

    // Range, full and empty checks against the current occupancy
    always_comb
    begin
        err_in = ERR_OK;
        case (op_in)
            OP_INSERT:
            begin
                if (count_reg == CAP_C)
                    err_in = ERR_FULL;
                else if (position > count_reg)
                    err_in = ERR_RANGE;
            end
            OP_REMOVE, OP_PEEK:
            begin
                if (count_reg == '0)
                    err_in = ERR_EMPTY;
                else if (position >= count_reg)
                    err_in = ERR_RANGE;
            end
            default: err_in = ERR_OK;
        endcase
    end

    // Capture the accepted word
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg   <= op_in;
            pos_reg  <= position;
            item_reg <= item_in;
            err_reg  <= err_in;
        end
    end

    // Status to the controller
    always_comb
    begin
        sts.op = op_reg;
        sts.ok = (err_reg == ERR_OK);
        if (op_reg == OP_INSERT)
        begin
            sts.at_end   = (pos_reg == count_reg);
            sts.src_last = (src_reg == pos_reg[ADDR_W-1:0]);
        end
        else
        begin
            sts.at_end   = (pos_reg == cnt_m1);
            sts.src_last = (src_reg == cnt_m1[ADDR_W-1:0]);
        end
    end

    // Shift pass: read one entry a cycle, write it one place over the next cycle
    always_comb
    begin
        src_next  = src_reg;
        dest_next = dest_reg;
        pend_next = 1'b0;
        if (ctl.shift_init)
        begin
            if (op_reg == OP_INSERT)
                src_next = cnt_m1[ADDR_W-1:0];
            else
                src_next = pos_p1[ADDR_W-1:0];
        end
        else if (ctl.shift_read)
        begin
            pend_next = 1'b1;
            if (op_reg == OP_INSERT)
            begin
                src_next  = src_reg - ADR_ONE;
                dest_next = src_reg + ADR_ONE;
            end
            else
            begin
                src_next  = src_reg + ADR_ONE;
                dest_next = src_reg - ADR_ONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg  <= src_next;
        dest_reg <= dest_next;
    end

    // RAM port selection; pending moves and the item write never coincide
    assign ram_we    = pend_reg | ctl.write_item;
    assign ram_waddr = ctl.write_item ? pos_reg[ADDR_W-1:0] : dest_reg;
    assign ram_wdata = ctl.write_item ? item_reg : ram_rdata;
    assign ram_re    = ctl.shift_read | ctl.peek_read;
    assign ram_raddr = ctl.peek_read ? pos_reg[ADDR_W-1:0] : src_reg;

    pls_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Occupancy update and result word
    always_comb
    begin
        count_next    = count_reg;
        item_out_next = item_out_reg;
        err_out_next  = err_out_reg;
        if (ctl.finish)
        begin
            err_out_next  = err_reg;
            item_out_next = '0;
            if (err_reg == ERR_OK)
            begin
                case (op_reg)
                    OP_INSERT: count_next    = count_reg + CNT_ONE;
                    OP_REMOVE: count_next    = cnt_m1;
                    OP_PEEK:   item_out_next = ram_rdata;
                    default:   count_next    = count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= ctl.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        item_out_reg <= item_out_next;
        err_out_reg  <= err_out_next;
    end

    assign done       = done_reg;
    assign item_out   = item_out_reg;
    assign error_code = err_out_reg;
    assign count      = count_reg;
    assign is_full    = (count_reg == CAP_C);
    assign is_empty   = (count_reg == '0);

endmodule

`default_nettype wire

// ----- sv/pls_ctrl.sv -----
// Controller: sequences check, shift pass, peek and write for one word.
`default_nettype none

module pls_ctrl
    import pls_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire pls_sts_t sts,
    output pls_ctl_t      ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT,
        S_DRAIN,
        S_PEEK,
        S_WRITE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!sts.ok)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    case (sts.op)
                        OP_PEEK:
                        begin
                            ctl.peek_read = 1'b1;
                            state_next    = S_PEEK;
                        end
                        OP_INSERT:
                        begin
                            if (sts.at_end)
                                state_next = S_WRITE;
                            else
                            begin
                                ctl.shift_init = 1'b1;
                                state_next     = S_SHIFT;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (sts.at_end)
                            begin
                                ctl.finish = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                ctl.shift_init = 1'b1;
                                state_next     = S_SHIFT;
                            end
                        end
                        default:
                        begin
                            ctl.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                ctl.shift_read = 1'b1;
                if (sts.src_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                // last moved entry is written this cycle
                if (sts.op == OP_INSERT)
                    state_next = S_WRITE;
                else
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_PEEK:
            begin
                ctl.finish = 1'b1;
                state_next = S_IDLE;
            end
            S_WRITE:
            begin
                ctl.write_item = 1'b1;
                ctl.finish     = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    // State and registered busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

// ----- sv/positional_list_store.sv -----
// Top level of the positional list store: controller plus datapath.
//
//  channel   direction  handshake         word
//  command   in         start & !busy     cmd, position, item_in
//  result    out        done (one cycle)  item_out, error_code, count, is_full, is_empty
//
// A refused word, an unused cmd or a remove of the last entry finishes after the check,
// a peek reads the entry at the position, and an insert at the tail writes its item.
// Other words first move the entries one place over from the position; an insert then writes.
// Entries move one per cycle through the RAM's one read port and one write port.
// busy drops in the cycle done shows, so the next word may be taken then.
// Reset clears occupancy and control; entry contents are left as they are.
// Results cannot be stalled by the receiver.
`default_nettype none

module positional_list_store
    import pls_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    cmd,
    input  wire logic [$clog2(CAPACITY+1)-1:0] position,
    input  wire logic [ITEM_WIDTH-1:0]         item_in,
    output logic                               done,
    output logic      [ITEM_WIDTH-1:0]         item_out,
    output logic      [1:0]                    error_code,
    output logic      [$clog2(CAPACITY+1)-1:0] count,
    output logic                               is_full,
    output logic                               is_empty
);

    pls_ctl_t ctl;
    pls_sts_t sts;

    pls_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    pls_dp #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .cmd_in     (cmd),
        .position   (position),
        .item_in    (item_in),
        .done       (done),
        .item_out   (item_out),
        .error_code (error_code),
        .count      (count),
        .is_full    (is_full),
        .is_empty   (is_empty)
    );

endmodule

`default_nettype wire

// ----- sv/pls_checker.sv -----
// Port-level checks for the positional list store, bound to the top level.
`default_nettype none

module pls_checker
    import pls_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          done,
    input wire logic [ITEM_WIDTH-1:0]         item_out,
    input wire logic [1:0]                    error_code,
    input wire logic [$clog2(CAPACITY+1)-1:0] count,
    input wire logic                          is_full,
    input wire logic                          is_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // An accepted word keeps the block busy until its result
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // busy ends exactly when a result word shows
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $fell(busy))
        else $error("result without a preceding busy interval");

    // Flags agree with the reported occupancy
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_full == (count == CNT_W'(CAPACITY))) && (is_empty == (count == '0)))
        else $error("full or empty flag disagrees with count");

    // A refused word carries no item
    a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error_code != ERR_OK) |-> (item_out == '0))
        else $error("refused word reported a nonzero item");

endmodule

bind positional_list_store pls_checker #(
    .CAPACITY   (CAPACITY),
    .ITEM_WIDTH (ITEM_WIDTH)
) u_pls_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .item_out   (item_out),
    .error_code (error_code),
    .count      (count),
    .is_full    (is_full),
    .is_empty   (is_empty)
);

`default_nettype wire
